@@ rtl/core/affine_vertex_transform_assert.svh @@
// Assertion macros for the affine vertex transform.
// Each macro checks an implication on the rising edge of aclk and is
// switched off while aresetn is low.
`ifndef AFFINE_VERTEX_TRANSFORM_ASSERT_SVH
`define AFFINE_VERTEX_TRANSFORM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define AVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("affine_vertex_transform: check failed");
// The consequent must hold in the cycle after the antecedent.
`define AVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("affine_vertex_transform: check failed");
`else
`define AVT_ASSERT_NOW(label, ante, cons)
`define AVT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/avt_pkg.sv @@
package avt_pkg;

    // Fixed-point formats: coordinates and offsets are signed Q12.12,
    // coefficients are signed Q4.12.
    localparam int COORD_W    = 24;
    localparam int COEF_W     = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int NUM_ROWS   = 3;
    localparam int NUM_COLS   = 3;
    localparam int LINEAR_W   = NUM_COLS * COEF_W;
    localparam int PROD_W     = COORD_W + COEF_W;
    // Three products plus the scaled offset need two growth bits.
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - FRAC_SHIFT;

    // Configuration port.
    localparam int CFG_DATA_W  = LINEAR_W;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_LINEAR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_LINEAR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_LINEAR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_OFFSET = 3'd5;

    // A coefficient of exactly one in Q4.12.
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SHIFT);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } avt_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      clipped;
    } avt_out_t;

    typedef struct packed {
        logic        [LINEAR_W-1:0] linear;
        logic signed [COORD_W-1:0]  offset;
    } row_coef_t;

    // Load strobes for the datapath stages.
    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
        logic ld_out;
    } stage_en_t;

endpackage

@@ rtl/core/avt_cfg.sv @@
module avt_cfg (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [avt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [avt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output avt_pkg::row_coef_t [avt_pkg::NUM_ROWS-1:0] row_coef
);

    logic        [avt_pkg::LINEAR_W-1:0] linear_reg  [avt_pkg::NUM_ROWS];
    logic        [avt_pkg::LINEAR_W-1:0] linear_next [avt_pkg::NUM_ROWS];
    logic signed [avt_pkg::COORD_W-1:0]  offset_reg  [avt_pkg::NUM_ROWS];
    logic signed [avt_pkg::COORD_W-1:0]  offset_next [avt_pkg::NUM_ROWS];

    always_comb begin
        for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
            linear_next[r] = linear_reg[r];
            offset_next[r] = offset_reg[r];
        end
        if (cfg_wr_en) begin
            unique case (cfg_index)
                avt_pkg::REG_ROW0_LINEAR: linear_next[0] = cfg_wdata[avt_pkg::LINEAR_W-1:0];
                avt_pkg::REG_ROW0_OFFSET: offset_next[0] = cfg_wdata[avt_pkg::COORD_W-1:0];
                avt_pkg::REG_ROW1_LINEAR: linear_next[1] = cfg_wdata[avt_pkg::LINEAR_W-1:0];
                avt_pkg::REG_ROW1_OFFSET: offset_next[1] = cfg_wdata[avt_pkg::COORD_W-1:0];
                avt_pkg::REG_ROW2_LINEAR: linear_next[2] = cfg_wdata[avt_pkg::LINEAR_W-1:0];
                avt_pkg::REG_ROW2_OFFSET: offset_next[2] = cfg_wdata[avt_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Reset loads the identity transform.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
                linear_reg[r] <= avt_pkg::LINEAR_W'(avt_pkg::COEF_ONE) << (r * avt_pkg::COEF_W);
                offset_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
                linear_reg[r] <= linear_next[r];
                offset_reg[r] <= offset_next[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
            row_coef[r].linear = linear_reg[r];
            row_coef[r].offset = offset_reg[r];
        end
    end

endmodule

@@ rtl/core/avt_row.sv @@
module avt_row (
    input  logic                              aclk,
    input  avt_pkg::stage_en_t                en,
    input  avt_pkg::row_coef_t                coef,
    input  avt_pkg::avt_in_t                  vtx,
    output logic signed [avt_pkg::COORD_W-1:0] coord,
    output logic                              sat
);

    logic signed [avt_pkg::COORD_W-1:0] vcoord    [avt_pkg::NUM_COLS];
    logic signed [avt_pkg::PROD_W-1:0]  prod_next [avt_pkg::NUM_COLS];
    logic signed [avt_pkg::PROD_W-1:0]  prod_reg  [avt_pkg::NUM_COLS];
    logic signed [avt_pkg::SUM_W-1:0]   offset_scaled;
    logic signed [avt_pkg::SUM_W-1:0]   sum_next;
    logic signed [avt_pkg::SUM_W-1:0]   sum_reg;
    logic signed [avt_pkg::SUM_W-1:0]   shifted;
    logic [avt_pkg::SHIFT_W-avt_pkg::COORD_W:0] upper;
    logic                               ovf;
    logic signed [avt_pkg::COORD_W-1:0] coord_next;
    logic signed [avt_pkg::COORD_W-1:0] coord_reg;
    logic                               sat_next;
    logic                               sat_reg;

    assign vcoord[0] = vtx.in_x;
    assign vcoord[1] = vtx.in_y;
    assign vcoord[2] = vtx.in_z;

    // Stage 1: one signed multiply per column.
    always_comb begin
        for (int c = 0; c < avt_pkg::NUM_COLS; c++) begin
            prod_next[c] = vcoord[c] *
                $signed(coef.linear[c*avt_pkg::COEF_W +: avt_pkg::COEF_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_mul) begin
            for (int c = 0; c < avt_pkg::NUM_COLS; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // Stage 2: exact sum with the offset moved up to 24 fraction bits.
    assign offset_scaled = $signed({
        {(avt_pkg::SUM_W-avt_pkg::COORD_W-avt_pkg::FRAC_SHIFT){coef.offset[avt_pkg::COORD_W-1]}},
        coef.offset,
        {avt_pkg::FRAC_SHIFT{1'b0}}});

    assign sum_next = avt_pkg::SUM_W'(prod_reg[0]) + avt_pkg::SUM_W'(prod_reg[1])
                    + avt_pkg::SUM_W'(prod_reg[2]) + offset_scaled;

    always_ff @(posedge aclk) begin
        if (en.ld_sum) begin
            sum_reg <= sum_next;
        end
    end

    // Stage 3: arithmetic shift floors; saturate when the bits above the
    // coordinate's sign bit disagree with it.
    assign shifted = sum_reg >>> avt_pkg::FRAC_SHIFT;
    assign upper   = shifted[avt_pkg::SHIFT_W-1:avt_pkg::COORD_W-1];
    assign ovf     = !((&upper) || !(|upper));

    always_comb begin
        sat_next = ovf;
        if (!ovf) begin
            coord_next = shifted[avt_pkg::COORD_W-1:0];
        end else if (shifted[avt_pkg::SHIFT_W-1]) begin
            coord_next = avt_pkg::COORD_MIN;
        end else begin
            coord_next = avt_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_out) begin
            coord_reg <= coord_next;
            sat_reg   <= sat_next;
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

@@ rtl/core/affine_vertex_transform.sv @@
// Accepted words pass the multiply, sum and saturate registers to reach m_data.
// Throughput: one word per cycle unless m_ready stalls; four register stages
// (input, multiply, sum, saturate) each load whenever the stage after can move.
// Reset (aresetn low at a rising edge) empties the pipeline and loads the
// identity transform with zero translation.
`include "affine_vertex_transform_assert.svh"

module affine_vertex_transform (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [avt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [avt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // Vertex input channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  avt_pkg::avt_in_t                      s_data,
    // Transformed vertex channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output avt_pkg::avt_out_t                     m_data
);

    // Each stage holds a valid bit. A stage can load when it is empty or when
    // the stage after it is loading, so a stalled output backs up the pipe one
    // stage at a time and bubbles are squeezed out.
    logic v_in_reg,  v_in_next;
    logic v_mul_reg, v_mul_next;
    logic v_sum_reg, v_sum_next;
    logic v_out_reg, v_out_next;

    logic rdy_in, rdy_mul, rdy_sum, rdy_out;

    avt_pkg::avt_in_t   in_reg;
    avt_pkg::stage_en_t stage_en;
    avt_pkg::row_coef_t [avt_pkg::NUM_ROWS-1:0] row_coef;

    logic signed [avt_pkg::COORD_W-1:0] row_coord [avt_pkg::NUM_ROWS];
    logic [avt_pkg::NUM_ROWS-1:0]       row_sat;

    assign rdy_out = !v_out_reg || m_ready;
    assign rdy_sum = !v_sum_reg || rdy_out;
    assign rdy_mul = !v_mul_reg || rdy_sum;
    assign rdy_in  = !v_in_reg  || rdy_mul;

    assign s_ready = rdy_in;

    // Data registers only load when a valid word moves into them.
    assign stage_en.ld_mul = rdy_mul && v_in_reg;
    assign stage_en.ld_sum = rdy_sum && v_mul_reg;
    assign stage_en.ld_out = rdy_out && v_sum_reg;

    assign v_in_next  = rdy_in  ? s_valid   : v_in_reg;
    assign v_mul_next = rdy_mul ? v_in_reg  : v_mul_reg;
    assign v_sum_next = rdy_sum ? v_mul_reg : v_sum_reg;
    assign v_out_next = rdy_out ? v_sum_reg : v_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg  <= 1'b0;
            v_mul_reg <= 1'b0;
            v_sum_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end else begin
            v_in_reg  <= v_in_next;
            v_mul_reg <= v_mul_next;
            v_sum_reg <= v_sum_next;
            v_out_reg <= v_out_next;
        end
    end

    // The input register cuts the path from the input ports to the multipliers.
    always_ff @(posedge aclk) begin
        if (s_valid && rdy_in) begin
            in_reg <= s_data;
        end
    end

    avt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .row_coef  (row_coef)
    );

    // One datapath per matrix row; all three share the stage strobes.
    for (genvar r = 0; r < avt_pkg::NUM_ROWS; r++) begin : g_row
        avt_row u_row (
            .aclk  (aclk),
            .en    (stage_en),
            .coef  (row_coef[r]),
            .vtx   (in_reg),
            .coord (row_coord[r]),
            .sat   (row_sat[r])
        );
    end

    // The result word comes straight from the row output registers; the
    // clipped flag is the OR of the three per-row saturation flags.
    always_comb begin
        m_data.out_x   = row_coord[0];
        m_data.out_y   = row_coord[1];
        m_data.out_z   = row_coord[2];
        m_data.clipped = |row_sat;
    end

    assign m_valid = v_out_reg;

    // The input side can only refuse a word when every stage is full and the
    // output is stalled.
    `AVT_ASSERT_NOW(a_full_when_blocked, !s_ready,
        v_in_reg && v_mul_reg && v_sum_reg && v_out_reg && !m_ready)
    // A word in the sum stage reaches the output once the output can move.
    `AVT_ASSERT_NEXT(a_sum_advances, v_sum_reg && rdy_out, m_valid)
    // A word held in the multiply stage is never dropped.
    `AVT_ASSERT_NEXT(a_mul_holds, v_mul_reg && !rdy_sum, v_mul_reg)
    // With nothing behind it, a delivered word leaves the output empty.
    `AVT_ASSERT_NEXT(a_out_drains, m_valid && m_ready && !v_sum_reg, !m_valid)

endmodule
